// ===== sv/ecc_pkg.sv =====
// Shared types, constants and helper functions of the epoch/calendar converter.
package ecc_pkg;

    // Request word: one conversion request
    typedef struct packed {
        logic        operation;
        logic [41:0] epoch_millis;
        logic [11:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
    } ecc_req_t;

    // Result word
    typedef struct packed {
        logic [41:0] millis_out;
        logic [11:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic [2:0]  weekday;
        logic        range_error;
    } ecc_res_t;

    // Output of the millisecond-to-calendar pipe
    typedef struct packed {
        logic        err;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
    } ecc_split_t;

    // Output of the calendar-to-millisecond pipe
    typedef struct packed {
        logic        err;
        logic [41:0] millis;
        logic [2:0]  wday;
    } ecc_build_t;

    // Operation codes
    localparam logic OP_TO_CAL    = 1'b0;
    localparam logic OP_TO_MILLIS = 1'b1;

    // Register stages from the input register to the last datapath register
    localparam int PIPE_DEPTH = 7;

    // Day numbers counted from 1970-01-01
    localparam logic [15:0] DAY_FIRST = 16'd10957;  // 2000-01-01
    localparam logic [15:0] DAY_LAST  = 16'd47481;  // 2099-12-31
    localparam logic [15:0] DAY_BASE  = 16'd9556;   // 1996-03-01, March-based cycle start
    localparam logic [11:0] YEAR_BASE = 12'd1996;
    localparam logic [11:0] YEAR_MIN  = 12'd2000;
    localparam logic [11:0] YEAR_MAX  = 12'd2099;

    // One day in ms is 2^10 * DAY_K
    localparam logic [16:0] DAY_K      = 17'd84375;
    localparam logic [26:0] MS_PER_DAY = 27'd86400000;

    // Round-up reciprocals: floor(n/d) == (n*m) >> (N+l) for every N-bit n
    localparam logic [33:0] RECIP_DAY  = 34'(((64'd1 << 49) + 64'd84374) / 64'd84375);
    localparam logic [24:0] RECIP_SEC  = 25'(((64'd1 << 31) + 64'd124) / 64'd125);
    localparam logic [18:0] RECIP_YEAR = 19'(((64'd1 << 29) + 64'd1460) / 64'd1461);
    localparam logic [17:0] RECIP_HOUR = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
    localparam logic [11:0] RECIP_MON  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
    localparam logic [12:0] RECIP_MIN  = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

    // Days before each March-based month: (153*m+2)/5
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Remainder by 7 through octal digit folding (8 is 1 mod 7)
    function automatic logic [2:0] mod7(input logic [16:0] v);
        logic [5:0] s;
        logic [3:0] s2;
        logic [3:0] s3;
        s  = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
           + 6'(v[14:12]) + 6'(v[16:15]);
        s2 = 4'(s[5:3]) + 4'(s[2:0]);
        s3 = 4'(s2[3]) + 4'(s2[2:0]);
        return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
    endfunction

endpackage

// ===== sv/epoch_calendar_converter.sv =====
// Top level of the epoch/calendar converter: input register, two pipes, output register.
//
// Takes one request word per clock (busy is always low) and returns its result
// word through seven register stages, the input register included, and the
// output register, marked by a one-cycle done strobe. The millisecond-to-date
// split, a chain of reciprocal multiplies, and the date-to-millisecond build
// have the same depth. Requests of both operations mix freely and results
// leave in request order. Results cannot be held off, so the receiver must
// take each word in its done cycle.
module epoch_calendar_converter
    import ecc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  ecc_req_t request,
    output logic     done,
    output ecc_res_t result
);

    logic                  valid_reg [PIPE_DEPTH];
    logic                  op_reg    [PIPE_DEPTH];
    ecc_req_t              req_reg;
    logic                  done_reg;
    ecc_res_t              result_reg;
    ecc_res_t              result_next;
    ecc_split_t            split_res;
    ecc_build_t            build_res;

    assign busy = 1'b0;

    // Hold the request word
    always_ff @(posedge clk)
    begin
        req_reg <= request;
    end

    // Advance valid bits and operation codes alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
                op_reg[i]    <= OP_TO_CAL;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start && !busy;
            op_reg[0]    <= request.operation;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
                op_reg[i]    <= op_reg[i-1];
            end
            done_reg <= valid_reg[PIPE_DEPTH-1];
        end
    end

    ecc_split u_split
    (
        .clk (clk),
        .req (req_reg),
        .res (split_res)
    );

    ecc_build u_build
    (
        .clk (clk),
        .req (req_reg),
        .res (build_res)
    );

    // Select by operation; drop all fields on a range error
    always_comb
    begin
        result_next = '0;
        if (op_reg[PIPE_DEPTH-1] == OP_TO_CAL)
        begin
            if (split_res.err)
                result_next.range_error = 1'b1;
            else
            begin
                result_next.year_out   = split_res.year;
                result_next.month_out  = split_res.month;
                result_next.day_out    = split_res.day;
                result_next.hour_out   = split_res.hour;
                result_next.minute_out = split_res.minute;
                result_next.second_out = split_res.second;
                result_next.weekday    = split_res.wday;
            end
        end
        else
        begin
            if (build_res.err)
                result_next.range_error = 1'b1;
            else
            begin
                result_next.millis_out = build_res.millis;
                result_next.weekday    = build_res.wday;
            end
        end
    end

    // Hold the result word
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##8 done)
        else $error("result word missing 8 cycles after start");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 8))
        else $error("result word without a request");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.range_error) |-> (result.millis_out == 42'd0
            && result.weekday == 3'd0 && result.year_out == 12'd0))
        else $error("fields not cleared on range error");

    a_wday: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.weekday != 3'd7))
        else $error("weekday out of range");

endmodule

// ===== sv/ecc_split.sv =====
// Millisecond-to-calendar pipeline: six register stages after the input register.
module ecc_split
    import ecc_pkg::*;
(
    input  logic       clk,
    input  ecc_req_t   req,
    output ecc_split_t res
);

    // Stage 2: day count
    logic [31:0] x2_reg;
    logic [9:0]  lo2_reg;
    logic [15:0] days2_reg;
    // Stage 3: ms of day, cycle day, range, weekday
    logic [26:0] msod3_reg;
    logic [15:0] t3_reg;
    logic        err3_reg;
    logic [2:0]  wd3_reg;
    // Stage 4: seconds of day, year in cycle
    logic [16:0] secs4_reg;
    logic [15:0] t4_reg;
    logic [6:0]  d4_reg;
    logic        err4_reg;
    logic [2:0]  wd4_reg;
    // Stage 5: day in year, hour
    logic [8:0]  e5_reg;
    logic [16:0] secs5_reg;
    logic [4:0]  hour5_reg;
    logic [6:0]  d5_reg;
    logic        err5_reg;
    logic [2:0]  wd5_reg;
    // Stage 6: month index, seconds of hour
    logic [3:0]  mq6_reg;
    logic [8:0]  e6_reg;
    logic [11:0] soh6_reg;
    logic [4:0]  hour6_reg;
    logic [6:0]  d6_reg;
    logic        err6_reg;
    logic [2:0]  wd6_reg;
    // Stage 7: date and minute
    logic [5:0]  min7_reg;
    logic [11:0] soh7_reg;
    logic [4:0]  day7_reg;
    logic [3:0]  mon7_reg;
    logic [11:0] year7_reg;
    logic [4:0]  hour7_reg;
    logic        err7_reg;
    logic [2:0]  wd7_reg;

    logic [65:0] prod_day;
    logic [15:0] days2_next;
    logic [32:0] dk;
    logic [16:0] rem3;
    logic [48:0] prod_sec;
    logic [17:0] n4;
    logic [36:0] prod_yr;
    logic [15:0] yq5;
    logic [34:0] prod_hr;
    logic [10:0] n6;
    logic [22:0] prod_mon;
    logic [16:0] hsec6;
    logic [24:0] prod_min;

    // Divide ms >> 10 by 84375 for the day count, and form the later stages' products
    always_comb
    begin
        prod_day   = 66'(req.epoch_millis[41:10]) * 66'(RECIP_DAY);
        days2_next = prod_day[64:49];
        dk         = 33'(days2_reg) * 33'(DAY_K);
        rem3       = 17'(33'(x2_reg) - dk);
        prod_sec   = 49'(msod3_reg[26:3]) * 49'(RECIP_SEC);
        n4         = {t3_reg, 2'b11};
        prod_yr    = 37'(n4) * 37'(RECIP_YEAR);
        yq5        = 16'((18'(d4_reg) * 18'd1461) >> 2);
        prod_hr    = 35'(secs4_reg) * 35'(RECIP_HOUR);
        n6         = 11'(11'(e5_reg) * 11'd5 + 11'd2);
        prod_mon   = 23'(n6) * 23'(RECIP_MON);
        hsec6      = 17'(hour5_reg) * 17'd3600;
        prod_min   = 25'(soh6_reg) * 25'(RECIP_MIN);
    end

    // Advance the pipeline every cycle
    always_ff @(posedge clk)
    begin
        x2_reg    <= req.epoch_millis[41:10];
        lo2_reg   <= req.epoch_millis[9:0];
        days2_reg <= days2_next;

        msod3_reg <= {rem3, lo2_reg};
        t3_reg    <= days2_reg - DAY_BASE;
        err3_reg  <= (days2_reg < DAY_FIRST) || (days2_reg > DAY_LAST);
        wd3_reg   <= mod7(17'(days2_reg) + 17'd4);

        secs4_reg <= prod_sec[47:31];
        t4_reg    <= t3_reg;
        d4_reg    <= prod_yr[35:29];
        err4_reg  <= err3_reg;
        wd4_reg   <= wd3_reg;

        e5_reg    <= 9'(t4_reg - yq5);
        secs5_reg <= secs4_reg;
        hour5_reg <= prod_hr[33:29];
        d5_reg    <= d4_reg;
        err5_reg  <= err4_reg;
        wd5_reg   <= wd4_reg;

        mq6_reg   <= prod_mon[22:19];
        e6_reg    <= e5_reg;
        soh6_reg  <= 12'(secs5_reg - hsec6);
        hour6_reg <= hour5_reg;
        d6_reg    <= d5_reg;
        err6_reg  <= err5_reg;
        wd6_reg   <= wd5_reg;

        min7_reg  <= prod_min[23:18];
        soh7_reg  <= soh6_reg;
        day7_reg  <= 5'(e6_reg - cum_days(mq6_reg) + 9'd1);
        mon7_reg  <= (mq6_reg < 4'd10) ? 4'(mq6_reg + 4'd3) : 4'(mq6_reg - 4'd9);
        year7_reg <= 12'(YEAR_BASE + 12'(d6_reg) + 12'(mq6_reg >= 4'd10));
        hour7_reg <= hour6_reg;
        err7_reg  <= err6_reg;
        wd7_reg   <= wd6_reg;
    end

    // Finish the seconds and pack the result
    always_comb
    begin
        res.err    = err7_reg;
        res.year   = year7_reg;
        res.month  = mon7_reg;
        res.day    = day7_reg;
        res.hour   = hour7_reg;
        res.minute = min7_reg;
        res.second = 6'(soh7_reg - 12'(12'(min7_reg) * 12'd60));
        res.wday   = wd7_reg;
    end

endmodule

// ===== sv/ecc_build.sv =====
// Calendar-to-millisecond pipeline: six register stages after the input register.
module ecc_build
    import ecc_pkg::*;
(
    input  logic       clk,
    input  ecc_req_t   req,
    output ecc_build_t res
);

    logic        err2_reg;
    logic [6:0]  yy2_reg;
    logic [3:0]  mm2_reg;
    logic [4:0]  dy2_reg;
    logic [16:0] sod2_reg;
    logic        err3_reg;
    logic [15:0] days3_reg;
    logic [16:0] sod3_reg;
    logic        err4_reg;
    logic [2:0]  wd4_reg;
    logic [42:0] dprod4_reg;
    logic [26:0] sprod4_reg;
    logic        err5_reg;
    logic [2:0]  wd5_reg;
    logic [41:0] ms5_reg;
    logic        err6_reg;
    logic [2:0]  wd6_reg;
    logic [41:0] ms6_reg;
    logic        err7_reg;
    logic [2:0]  wd7_reg;
    logic [41:0] ms7_reg;

    logic        bad;
    logic        early;

    // Check fields; January and February belong to the previous March-based year
    always_comb
    begin
        bad   = (req.year_in < YEAR_MIN) || (req.year_in > YEAR_MAX)
             || (req.month_in == 4'd0) || (req.month_in > 4'd12)
             || (req.day_in == 5'd0) || (req.hour_in > 5'd23)
             || (req.minute_in > 6'd59) || (req.second_in > 6'd59);
        early = (req.month_in < 4'd3);
    end

    // Advance the pipeline every cycle
    always_ff @(posedge clk)
    begin
        err2_reg   <= bad;
        yy2_reg    <= 7'(req.year_in - YEAR_BASE - 12'(early));
        mm2_reg    <= early ? 4'(req.month_in + 4'd9) : 4'(req.month_in - 4'd3);
        dy2_reg    <= req.day_in;
        sod2_reg   <= 17'(17'(req.hour_in) * 17'd3600 + 17'(req.minute_in) * 17'd60
                          + 17'(req.second_in));

        err3_reg   <= err2_reg;
        days3_reg  <= 16'(DAY_BASE + 16'(yy2_reg) * 16'd365 + 16'(yy2_reg >> 2)
                          + 16'(cum_days(mm2_reg)) + 16'(dy2_reg) - 16'd1);
        sod3_reg   <= sod2_reg;

        err4_reg   <= err3_reg;
        wd4_reg    <= mod7(17'(days3_reg) + 17'd4);
        dprod4_reg <= 43'(days3_reg) * 43'(MS_PER_DAY);
        sprod4_reg <= 27'(27'(sod3_reg) * 27'd1000);

        err5_reg   <= err4_reg;
        wd5_reg    <= wd4_reg;
        ms5_reg    <= 42'(dprod4_reg + 43'(sprod4_reg));

        err6_reg   <= err5_reg;
        wd6_reg    <= wd5_reg;
        ms6_reg    <= ms5_reg;

        err7_reg   <= err6_reg;
        wd7_reg    <= wd6_reg;
        ms7_reg    <= ms6_reg;
    end

    assign res = '{err: err7_reg, millis: ms7_reg, wday: wd7_reg};

endmodule

// ===== dv/tb_epoch_calendar_converter.sv =====
// Testbench of the epoch/calendar converter: directed and random conversions checked in order.
`timescale 1ns / 1ps

module tb_epoch_calendar_converter;
    import ecc_pkg::*;

    localparam int LATENCY     = 8;
    localparam int RANDOM_WORDS = 750;
    localparam longint CYCLE_LIMIT = 200000;

    // Expected-result store with the conversion predictor
    class date_scoreboard;
        ecc_res_t pending[$];
        int       errors;
        int       checked;
        int       ranged;

        // Day number of a Gregorian date
        function automatic longint day_number(longint yr, longint mo, longint dy);
            longint a;
            longint y;
            longint m;
            a = (mo < 3) ? 1 : 0;
            y = yr + 4800 - a;
            m = mo + 12 * a - 3;
            return dy + (153 * m + 2) / 5 + 365 * y + y / 4 - y / 100 + y / 400 - 32045;
        endfunction

        function automatic ecc_res_t convert(ecc_req_t rq);
            ecc_res_t r;
            longint secs, days, sod, jdn, a, b, c, d, e, m, yr, mo, dy, ms;
            r = '0;
            if (rq.operation == OP_TO_CAL) begin
                secs = longint'(rq.epoch_millis) / 1000;
                days = secs / 86400;
                sod  = secs % 86400;
                jdn  = 2440588 + days;
                a = jdn + 32044;
                b = (4 * a + 3) / 146097;
                c = a - (146097 * b) / 4;
                d = (4 * c + 3) / 1461;
                e = c - (1461 * d) / 4;
                m = (5 * e + 2) / 153;
                yr = 100 * b + d + m / 10 - 4800;
                mo = m + 3 - 12 * (m / 10);
                dy = e - (153 * m + 2) / 5 + 1;
                if (yr < 2000 || yr > 2099) begin
                    r.range_error = 1'b1;
                end
                else begin
                    r.year_out   = 12'(yr);
                    r.month_out  = 4'(mo);
                    r.day_out    = 5'(dy);
                    r.hour_out   = 5'(sod / 3600);
                    r.minute_out = 6'((sod % 3600) / 60);
                    r.second_out = 6'(sod % 60);
                    r.weekday    = 3'((jdn + 1) % 7);
                end
            end
            else begin
                if (rq.year_in < 2000 || rq.year_in > 2099 || rq.month_in < 1
                    || rq.month_in > 12 || rq.day_in < 1 || rq.hour_in > 23
                    || rq.minute_in > 59 || rq.second_in > 59) begin
                    r.range_error = 1'b1;
                end
                else begin
                    jdn = day_number(rq.year_in, rq.month_in, rq.day_in);
                    ms = (jdn - 2440588) * 86400000
                       + (longint'(rq.hour_in) * 3600 + rq.minute_in * 60 + rq.second_in) * 1000;
                    r.millis_out = 42'(ms);
                    r.weekday    = 3'((jdn + 1) % 7);
                end
            end
            return r;
        endfunction

        function void note_request(ecc_req_t rq);
            pending.push_back(convert(rq));
        endfunction

        function void check_result(ecc_res_t got);
            ecc_res_t want;
            checked++;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want.range_error) ranged++;
            if (got.millis_out != want.millis_out) begin
                $error("millis_out expected %0d got %0d", want.millis_out, got.millis_out);
                errors++;
            end
            if (got.year_out != want.year_out) begin
                $error("year_out expected %0d got %0d", want.year_out, got.year_out);
                errors++;
            end
            if (got.month_out != want.month_out) begin
                $error("month_out expected %0d got %0d", want.month_out, got.month_out);
                errors++;
            end
            if (got.day_out != want.day_out) begin
                $error("day_out expected %0d got %0d", want.day_out, got.day_out);
                errors++;
            end
            if (got.hour_out != want.hour_out) begin
                $error("hour_out expected %0d got %0d", want.hour_out, got.hour_out);
                errors++;
            end
            if (got.minute_out != want.minute_out) begin
                $error("minute_out expected %0d got %0d", want.minute_out, got.minute_out);
                errors++;
            end
            if (got.second_out != want.second_out) begin
                $error("second_out expected %0d got %0d", want.second_out, got.second_out);
                errors++;
            end
            if (got.weekday != want.weekday) begin
                $error("weekday expected %0d got %0d", want.weekday, got.weekday);
                errors++;
            end
            if (got.range_error != want.range_error) begin
                $error("range_error expected %0d got %0d", want.range_error, got.range_error);
                errors++;
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ecc_req_t request;
    logic     done;
    ecc_res_t result;
    longint   cycles;
    int       sent;
    date_scoreboard board;

    epoch_calendar_converter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check each result word at the edge that ends its strobe cycle
    always @(posedge clk)
    begin
        if (rst_n && done) board.check_result(result);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one word, hold until taken, then, when idle is set, wait a random gap
    task automatic send_word(ecc_req_t rq, bit idle);
        int gap;
        start   <= 1'b1;
        request <= rq;
        do @(posedge clk); while (busy);
        board.note_request(rq);
        sent++;
        @(negedge clk);
        gap = idle ? $urandom_range(0, 17) : 0;
        if (gap != 0) begin
            start   <= 1'b0;
            request <= ecc_req_t'({$urandom, $urandom, $urandom});
            repeat (gap) @(negedge clk);
        end
    endtask

    // Date-to-millis word with the given fields; other bits random
    function automatic ecc_req_t calendar_word(int yr, int mo, int dy, int hr, int mi, int se);
        ecc_req_t rq;
        rq = ecc_req_t'({$urandom, $urandom, $urandom});
        rq.operation = OP_TO_MILLIS;
        rq.year_in   = 12'(yr);
        rq.month_in  = 4'(mo);
        rq.day_in    = 5'(dy);
        rq.hour_in   = 5'(hr);
        rq.minute_in = 6'(mi);
        rq.second_in = 6'(se);
        return rq;
    endfunction

    function automatic ecc_req_t millis_word(longint ms);
        ecc_req_t rq;
        rq = ecc_req_t'({$urandom, $urandom, $urandom});
        rq.operation    = OP_TO_CAL;
        rq.epoch_millis = 42'(ms);
        return rq;
    endfunction

    function automatic ecc_req_t random_word();
        ecc_req_t rq;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            // millis within the valid century, occasionally a little outside
            return millis_word(64'd946684800000 - 64'd86400000
                + (longint'($urandom) * 4096 + $urandom_range(0, 4095))
                  % 64'd3155846400000);
        end
        else if (pick == 4) begin
            return millis_word({$urandom, $urandom});
        end
        else if (pick < 9) begin
            return calendar_word($urandom_range(2000, 2099), $urandom_range(1, 12),
                $urandom_range(1, 31), $urandom_range(0, 23), $urandom_range(0, 59),
                $urandom_range(0, 59));
        end
        rq = ecc_req_t'({$urandom, $urandom, $urandom});
        rq.operation = OP_TO_MILLIS;
        return rq;
    endfunction

    initial
    begin
        bit idle;
        board   = new();
        cycles  = 0;
        sent    = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: edges of the century, fields, invalid values, month overflow
        send_word(millis_word(0), 1'b0);
        send_word(millis_word(64'd946684800000), 1'b0);
        send_word(millis_word(64'd946684799999), 1'b1);
        send_word(millis_word(64'd4102444799999), 1'b0);
        send_word(millis_word(64'd4102444800000), 1'b0);
        send_word(millis_word(64'd4398046511103), 1'b1);
        send_word(millis_word(64'd951782400999), 1'b0);
        send_word(calendar_word(2000, 1, 1, 0, 0, 0), 1'b0);
        send_word(calendar_word(2099, 12, 31, 23, 59, 59), 1'b0);
        send_word(calendar_word(1999, 12, 31, 0, 0, 0), 1'b1);
        send_word(calendar_word(2100, 1, 1, 0, 0, 0), 1'b0);
        send_word(calendar_word(4095, 15, 31, 31, 63, 63), 1'b0);
        send_word(calendar_word(0, 0, 0, 0, 0, 0), 1'b0);
        send_word(calendar_word(2050, 0, 5, 1, 1, 1), 1'b0);
        send_word(calendar_word(2050, 13, 5, 1, 1, 1), 1'b0);
        send_word(calendar_word(2050, 6, 0, 1, 1, 1), 1'b1);
        send_word(calendar_word(2050, 6, 5, 24, 1, 1), 1'b0);
        send_word(calendar_word(2050, 6, 5, 1, 60, 1), 1'b0);
        send_word(calendar_word(2050, 6, 5, 1, 1, 60), 1'b0);
        send_word(calendar_word(2001, 2, 31, 12, 0, 0), 1'b0);
        send_word(calendar_word(2000, 2, 29, 12, 0, 0), 1'b0);
        send_word(calendar_word(2024, 4, 31, 5, 6, 7), 1'b0);

        // Random: bursts alternate with idle stretches; drain once midway
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            idle = ((i / 60) % 2) == 1;
            send_word(random_word(), idle);
            if (i == RANDOM_WORDS / 2) begin
                start <= 1'b0;
                while (board.pending.size() != 0) @(negedge clk);
            end
        end
        start <= 1'b0;

        // Drain
        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);

        $display("Converted %0d words (%0d flagged out of range), checked %0d results.",
            sent, board.ranged, board.checked);
        if (board.errors == 0) begin
            $display("Test completed successfully");
        end
        else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
